[design/wbps_pkg.sv]
// Package for the wildcard byte pattern scanner.
// Holds sizing constants, register index codes and the types shared by the cell row and top level.
// No dependencies.
package wbps_pkg;

    // Window depth and byte counter width.
    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;

    // The pattern registers carry sixteen bytes; the usable length is the smaller limit.
    localparam int REG_BYTES = 16;
    localparam int EFF_MAX   = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int PIDX_W    = $clog2(REG_BYTES);
    localparam int LEN_W     = 5;
    localparam int REGION_W  = 16;
    localparam int OUT_OFS_W = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Register index codes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd3;

    // Per-word control handed to every cell.
    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctrl_t;

    // Compare status from one cell.
    typedef struct packed {
        logic ok;
        logic fixed;
    } cell_stat_t;

endpackage

[design/wbps_cell.sv]
// One window cell of the scanner: holds one byte of the sliding window and compares
// the byte it is about to take against its selected pattern byte.
// Depends on wbps_pkg.
module wbps_cell import wbps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] d_in,
    input  logic [7:0] pat_byte,
    input  logic       wild,
    input  logic       in_use,
    output logic [7:0] d_out,
    output cell_stat_t stat
);

    logic [7:0] byte_reg;

    // The window shifts by one cell per accepted word and clears at region end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else if (ctrl.shift) begin
            byte_reg <= ctrl.clr ? 8'd0 : d_in;
        end
    end

    assign d_out = byte_reg;

    // The incoming byte is this cell's content once the window has shifted.
    assign stat.ok    = !in_use || wild || (d_in == pat_byte);
    assign stat.fixed = in_use && !wild;

endmodule

[design/wildcard_byte_pattern_scanner_core.sv]
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg and wbps_cell.
//
// Usage: bytes enter on the s_ channel, one word per byte: s_tdata is the byte,
// s_tlast marks the last byte of a region and s_tuser the last byte of the scan.
// The pattern, its wildcard mask and its length are written on the cfg_ port
// while the block is idle. Each scan gives at most one word on the m_ channel:
// m_tuser is 1 for the first match and 0 for a scan that ended without one;
// m_tdata carries the region number and the offset of the match start.
// Throughput is one byte per cycle while the skid register is empty: a row of
// window cells shifts and compares all pattern positions in the same cycle the
// byte is accepted. Each result is registered in the output or skid register.
// The result side has an output register and a one-word skid register; while
// the receiver stalls, s_tready stays high until the skid register is taken,
// then drops until the output frees up. Reset (aresetn low, synchronous) clears
// the window, the counters, the result valid flags and the configuration
// (length 1, all other registers zero).
module wildcard_byte_pattern_scanner_core import wbps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input byte stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_region
    input  logic                 s_tuser,   // end_of_scan
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [15:0] region_number, [47:16] match_offset
    output logic                 m_tuser    // found
);

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [REGION_W-1:0]    REGION_MAX = '1;

    // Configuration registers.
    logic [CFG_W-1:0]     pat_lo_reg;
    logic [CFG_W-1:0]     pat_hi_reg;
    logic [REG_BYTES-1:0] wild_reg;
    logic [LEN_W-1:0]     len_reg;

    // Scan state.
    logic [OFFSET_BITS-1:0] count_reg;
    logic [REGION_W-1:0]    region_reg;
    logic                   reported_reg;

    // Result output and skid registers.
    logic                   m_valid_reg;
    logic                   m_found_reg;
    logic [47:0]            m_data_reg;
    logic                   skid_valid_reg;
    logic                   skid_found_reg;
    logic [47:0]            skid_data_reg;

    logic                   accept;
    logic [LEN_W-1:0]       eff_len;
    logic [2*CFG_W-1:0]     pat_bits;
    logic [OFFSET_BITS-1:0] count_next;
    logic [OFFSET_BITS-1:0] ofs_full;
    logic [OFFSET_BITS+OUT_OFS_W-1:0] ofs_ext;
    logic                   enough;
    logic                   all_ok;
    logic                   any_fixed;
    logic                   hit;
    logic                   miss;
    logic                   res_valid;
    logic [47:0]            res_data;
    logic                   out_free;

    cell_ctrl_t             ctrl;
    cell_stat_t             stat   [MAX_PATTERN];
    logic [7:0]             chain  [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] ok_vec;
    logic [MAX_PATTERN-1:0] fixed_vec;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            len_reg    <= LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PAT_LO:   pat_lo_reg <= cfg_data;
                REG_PAT_HI:   pat_hi_reg <= cfg_data;
                REG_WILDCARD: wild_reg   <= cfg_data[REG_BYTES-1:0];
                REG_LENGTH:   len_reg    <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Length in use, clamped to the window depth.
    assign eff_len  = (len_reg > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX) : len_reg;
    assign pat_bits = {pat_hi_reg, pat_lo_reg};

    assign accept     = s_tvalid && s_tready;
    assign ctrl.shift = accept;
    assign ctrl.clr   = s_tlast || s_tuser;
    assign chain[0]   = s_tdata;

    // Row of window cells; cell k compares against pattern byte eff_len-1-k.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [LEN_W-1:0]  pidx_full;
        logic [PIDX_W-1:0] pidx;
        logic              in_use;

        assign in_use    = int'(eff_len) > k;
        assign pidx_full = LEN_W'(eff_len - LEN_W'(1) - LEN_W'(k));
        assign pidx      = pidx_full[PIDX_W-1:0];

        wbps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .d_in     (chain[k]),
            .pat_byte (pat_bits[pidx*8 +: 8]),
            .wild     (wild_reg[pidx]),
            .in_use   (in_use),
            .d_out    (chain[k+1]),
            .stat     (stat[k])
        );

        assign ok_vec[k]    = stat[k].ok;
        assign fixed_vec[k] = stat[k].fixed;
    end

    // Match decision for the byte being accepted.
    assign all_ok     = &ok_vec;
    assign any_fixed  = |fixed_vec;
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + OFFSET_BITS'(1);
    assign enough     = count_next >= OFFSET_BITS'(eff_len);
    assign ofs_full   = count_next - OFFSET_BITS'(eff_len);
    assign ofs_ext    = {{OUT_OFS_W{1'b0}}, ofs_full};

    assign hit  = accept && !reported_reg && (eff_len != '0) && enough && all_ok && any_fixed;
    assign miss = accept && s_tuser && !reported_reg && !hit;

    assign res_valid = hit || miss;
    assign res_data  = hit ? {ofs_ext[OUT_OFS_W-1:0], region_reg} : 48'd0;

    // Region and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            region_reg   <= '0;
            reported_reg <= 1'b0;
        end else if (accept) begin
            if (s_tuser) begin
                count_reg    <= '0;
                region_reg   <= '0;
                reported_reg <= 1'b0;
            end else if (s_tlast) begin
                count_reg    <= '0;
                reported_reg <= reported_reg || hit;
                if (region_reg != REGION_MAX) begin
                    region_reg <= region_reg + REGION_W'(1);
                end
            end else begin
                count_reg    <= count_next;
                reported_reg <= reported_reg || hit;
            end
        end
    end

    // Output register with a one-word skid register behind it.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload follows the same steering as the valid bits.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_found_reg <= skid_found_reg;
                m_data_reg  <= skid_data_reg;
            end else if (res_valid) begin
                m_found_reg <= hit;
                m_data_reg  <= res_data;
            end
        end else if (res_valid) begin
            skid_found_reg <= hit;
            skid_data_reg  <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_data_reg;

endmodule

[design/wbps_checker.sv]
// Port-level checker for the wildcard byte pattern scanner, bound to the top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner_core.
module wbps_checker import wbps_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [47:0]          m_tdata,
    input logic                 m_tuser
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // A not-found word carries zero region and offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 48'd0)
        else $error("not-found word with nonzero fields");

    // A new result word only follows an accepted input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted input");

    // Reset empties the result side.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/wbps_scan_checker.sv]
// Checker for the wildcard byte pattern scanner: watches the config port and both streams,
// predicts the result word of every scan and compares it with what the block sends.
// Depends on wbps_pkg.
module wbps_scan_checker import wbps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_region
    input  logic                 s_tuser,   // end_of_scan
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,   // [15:0] region_number, [47:16] match_offset
    input  logic                 m_tuser,   // found
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                  found;
        logic [REGION_W-1:0]   region;
        logic [OUT_OFS_W-1:0]  offset;
    } scan_result_t;

    // Configuration as the block should hold it.
    logic [2*CFG_W-1:0]   pattern;
    logic [15:0]          wildcards;
    logic [LEN_W-1:0]     length_reg;

    // Scan state.
    logic [7:0]             window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] seen;
    logic [REGION_W-1:0]    region;
    logic                   reported;

    scan_result_t results_due [$];

    task automatic flag_error(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // Append one predicted result word at the tail of the queue.
    task automatic queue_result(input scan_result_t r);
        results_due = {results_due, r};
    endtask

    task automatic clear_region();
        for (int i = 0; i < MAX_PATTERN; i++) begin
            window[i] = 8'h00;
        end
        seen = '0;
    endtask

    // True when every fixed pattern byte lines up with the window; window[0] is the newest.
    function automatic logic window_hit(input int len);
        logic any_fixed;
        any_fixed = 1'b0;
        if (len == 0 || seen < len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (!wildcards[i]) begin
                any_fixed = 1'b1;
                if (window[len - 1 - i] != pattern[i*8 +: 8]) return 1'b0;
            end
        end
        return any_fixed;
    endfunction

    // Shift one byte in and queue the result word it causes, if any.
    task automatic advance_window(input logic [7:0] b, input logic eor, input logic eos);
        int len;
        scan_result_t r;
        for (int i = MAX_PATTERN - 1; i > 0; i--) begin
            window[i] = window[i - 1];
        end
        window[0] = b;
        if (seen != '1) seen = seen + 1'b1;
        len = (length_reg > EFF_MAX) ? EFF_MAX : int'(length_reg);

        if (!reported && window_hit(len)) begin
            r.found  = 1'b1;
            r.region = region;
            r.offset = OUT_OFS_W'(seen - OFFSET_BITS'(len));
            queue_result(r);
            reported = 1'b1;
        end

        // A scan end closes the region too and starts the next scan from scratch.
        if (eos) begin
            if (!reported) begin
                r = '0;
                queue_result(r);
            end
            clear_region();
            region   = '0;
            reported = 1'b0;
        end else if (eor) begin
            clear_region();
            if (region != '1) region = region + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            pattern    = '0;
            wildcards  = '0;
            length_reg = LEN_W'(1);
            clear_region();
            region     = '0;
            reported   = 1'b0;
            results_due.delete();
            pending    <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PAT_LO:   pattern[CFG_W-1:0]       = cfg_data;
                    REG_PAT_HI:   pattern[2*CFG_W-1:CFG_W] = cfg_data;
                    REG_WILDCARD: wildcards                = cfg_data[15:0];
                    REG_LENGTH:   length_reg               = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                advance_window(s_tdata, s_tlast, s_tuser);
            end

            // Compare each result word with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    flag_error($sformatf(
                        "result word with none expected: found=%0d region=%0d offset=%0d",
                        m_tuser, m_tdata[15:0], m_tdata[47:16]));
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.found || m_tdata[15:0] !== want.region ||
                            m_tdata[47:16] !== want.offset) begin
                        flag_error($sformatf({"result mismatch: expected found=%0d ",
                            "region=%0d offset=%0d, got found=%0d region=%0d offset=%0d"},
                            want.found, want.region, want.offset,
                            m_tuser, m_tdata[15:0], m_tdata[47:16]));
                    end
                end
            end
            pending <= results_due.size();
        end
    end

endmodule

[verif/tb_wildcard_byte_pattern_scanner_core.sv]
// Testbench top for the wildcard byte pattern scanner: drives clock, reset, the config
// port and both streams, and prints the verdict.
// Depends on wbps_pkg, wildcard_byte_pattern_scanner_core and wbps_scan_checker.
module tb_wildcard_byte_pattern_scanner_core import wbps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1200;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    int                   fail_count;
    int                   pending;

    // Stimulus-side copy of the pattern, used to plant matches.
    logic [2*CFG_W-1:0] cur_pattern = '0;
    logic [15:0]        cur_wild    = '0;
    int                 cur_plen    = 1;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int total_items  = 0;
    int rx_hold      = 0;
    int quiet_cycles = 0;
    int phase, random_base, phase_base;
    logic [63:0] cfg_lo, cfg_hi, cfg_wild, cfg_len;

    wildcard_byte_pattern_scanner_core uut (.*);
    wbps_scan_checker chk (.*);

    always #1 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        return cur_pattern[i*8 +: 8];
    endfunction

    // Receiver side: random stalls on m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            rx_hold  <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any word moving on either stream ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, after an optional gap, and hold it until it is taken.
    task automatic send_word(input logic [7:0] b, input logic eor, input logic eos);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        s_tuser  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        total_items++;
    endtask

    // Stop sending and wait until every predicted result word has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // Load all four registers while the block is idle.
    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] wild, input logic [63:0] len);
        wait_idle();
        cfg_write(REG_PAT_LO, lo);
        cfg_write(REG_PAT_HI, hi);
        cfg_write(REG_WILDCARD, wild);
        cfg_write(REG_LENGTH, len);
        cfg_we      <= 1'b0;
        cur_pattern = {hi, lo};
        cur_wild    = wild[15:0];
        cur_plen    = (len[4:0] > 16) ? 16 : int'(len[4:0]);
    endtask

    // One scan of one to three regions; most regions carry a planted or nearly planted pattern.
    task automatic send_scan();
        int n_regions, rlen, pos, flip;
        logic [7:0] rbuf [64];
        logic scan_end;
        n_regions = $urandom_range(1, 3);
        for (int r = 0; r < n_regions; r++) begin
            rlen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 48);
            for (int i = 0; i < rlen; i++) begin
                rbuf[i] = $urandom_range(0, 1) ? 8'($urandom)
                                               : pattern_byte($urandom_range(0, 15));
            end
            if (cur_plen > 0 && rlen >= cur_plen && $urandom_range(0, 99) < 60) begin
                pos = $urandom_range(0, rlen - cur_plen);
                for (int i = 0; i < cur_plen; i++) begin
                    if (!cur_wild[i]) rbuf[pos + i] = pattern_byte(i);
                end
                // Spoil one byte now and then to get near misses.
                if ($urandom_range(0, 99) < 30) begin
                    flip = $urandom_range(0, cur_plen - 1);
                    rbuf[pos + flip] ^= 8'(1 << $urandom_range(0, 7));
                end
            end
            for (int i = 0; i < rlen; i++) begin
                scan_end = (r == n_regions - 1) && (i == rlen - 1);
                send_word(rbuf[i], (i == rlen - 1) && (!scan_end || $urandom_range(0, 1)),
                          scan_end);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset pattern (one fixed byte 0x00).
        tx_idle_pct  = 25;
        rx_stall_pct = 25;
        // First match reported, the later one in the same scan ignored.
        send_word(8'h11, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        // Scan without a match.
        send_word(8'h80, 1'b0, 1'b1);
        // Match completed by the scan's last byte.
        send_word(8'h42, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // Match in the second region.
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);

        // AA ?? 55: a match spanning the region boundary must not count.
        set_pattern(64'h0000_0000_0055_00AA, 64'h0, 64'h2, 64'd3);
        send_word(8'h12, 1'b0, 1'b0);
        send_word(8'hAA, 1'b0, 1'b0);
        send_word(8'h77, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'hAA, 1'b0, 1'b0);
        send_word(8'h31, 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b1);

        // A pattern of wildcards only never matches.
        set_pattern(64'h0, 64'h0, 64'h3, 64'd2);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);

        // Length zero never matches.
        set_pattern(64'h0, 64'h0, 64'h0, 64'd0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);

        // Random scans under a series of pattern settings.
        phase       = 0;
        random_base = total_items;
        while (total_items - random_base < RANDOM_ITEMS) begin
            cfg_lo   = {$urandom, $urandom};
            cfg_hi   = {$urandom, $urandom};
            cfg_wild = {$urandom, $urandom};
            cfg_len  = {$urandom, $urandom};
            case (phase % 8)
                0: begin
                    cfg_wild[15:0] = '0;
                    cfg_len[4:0]   = 5'd16;
                end
                1: cfg_len[4:0] = 5'd1;
                2: begin
                    cfg_wild[15:0] = 16'($urandom & $urandom);
                    cfg_len[4:0]   = 5'($urandom_range(2, 15));
                end
                3: begin
                    cfg_wild[15:0] = ~(16'h1 << $urandom_range(0, 15));
                    cfg_len[4:0]   = 5'd16;
                end
                4: begin
                    cfg_wild[15:0] = '1;
                    cfg_len[4:0]   = 5'($urandom_range(1, 16));
                end
                5: cfg_len[4:0] = 5'd0;
                6: cfg_len[4:0] = 5'($urandom_range(17, 31));
                default: begin
                    cfg_wild[15:0] = 16'($urandom & $urandom);
                    cfg_len[4:0]   = 5'($urandom_range(1, 16));
                end
            endcase
            set_pattern(cfg_lo, cfg_hi, cfg_wild, cfg_len);
            case (phase % 3)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 25;
                    rx_stall_pct = 25;
                end
                default: begin
                    tx_idle_pct  = 60;
                    rx_stall_pct = 60;
                end
            endcase
            phase_base = total_items;
            while (total_items - phase_base < PHASE_ITEMS) send_scan();
            phase++;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
